@@ hdl/dec96_pkg.sv @@
// Shared types, constants and helpers for the 96-bit decimal rounding unit.
package dec96_pkg;

    localparam int MANT_W  = 96;
    localparam int NIB_W   = 4;
    localparam int NIBBLES = MANT_W / NIB_W;
    localparam int NIB_CW  = $clog2(NIBBLES);

    typedef enum logic [1:0] {
        OP_TRUNC  = 2'd0,
        OP_FLOOR  = 2'd1,
        OP_ROUND  = 2'd2,
        OP_NEGATE = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_INC  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic inc_step;
        logic first;
        logic last;
        logic bump;
    } t_dp_ctrl;

    typedef struct packed {
        logic [3:0] last_digit;
        logic       sticky;
        logic       lsb;
    } t_dp_stat;

    // One long-division step by ten: {remainder, nibble} in, {quotient, remainder} out.
    function automatic logic [7:0] div10_nib(input logic [7:0] cur);
        logic [15:0] prod;
        logic [3:0]  q;
        logic [7:0]  r;
        prod = 16'(cur) * 16'd205;
        q    = prod[14:11];
        r    = cur - 8'(q) * 8'd10;
        return {q, r[3:0]};
    endfunction

endpackage

@@ hdl/dec96_if.sv @@
// Valid/ready channel interfaces for the operand items and the result items.
interface dec96_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [63:0] mant_lo;
    logic [31:0] mant_hi;
    logic [4:0]  scale;
    logic        sign;

    modport source (output valid, op, mant_lo, mant_hi, scale, sign, input ready);
    modport sink   (input valid, op, mant_lo, mant_hi, scale, sign, output ready);
endinterface

interface dec96_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] res_lo;
    logic [31:0] res_hi;
    logic [4:0]  res_scale;
    logic        res_sign;

    modport source (output valid, res_lo, res_hi, res_scale, res_sign, input ready);
    modport sink   (input valid, res_lo, res_hi, res_scale, res_sign, output ready);
endinterface

@@ hdl/dec96_datapath.sv @@
// Nibble-serial mantissa shift register with divide-by-ten and increment steps.
module dec96_datapath (
    input  logic                          i_clk,
    input  dec96_pkg::t_dp_ctrl           i_ctrl,
    input  logic [dec96_pkg::MANT_W-1:0]  i_load_mant,
    output logic [dec96_pkg::MANT_W-1:0]  o_mant,
    output dec96_pkg::t_dp_stat           o_stat
);
    import dec96_pkg::*;

    logic [MANT_W-1:0] r_mant, n_mant;
    logic [3:0]        r_rem, n_rem;
    logic [3:0]        r_last, n_last;
    logic              r_sticky, n_sticky;
    logic              r_carry, n_carry;

    logic [3:0] rem_in;
    logic [7:0] qr;
    logic [4:0] sum;

    always_comb begin
        rem_in   = i_ctrl.first ? 4'd0 : r_rem;
        qr       = div10_nib({rem_in, r_mant[MANT_W-1 -: NIB_W]});
        sum      = 5'(r_mant[NIB_W-1:0]) + 5'(i_ctrl.first ? i_ctrl.bump : r_carry);
        n_mant   = r_mant;
        n_rem    = r_rem;
        n_last   = r_last;
        n_sticky = r_sticky;
        n_carry  = r_carry;
        if (i_ctrl.load) begin
            n_mant   = i_load_mant;
            n_rem    = '0;
            n_last   = '0;
            n_sticky = 1'b0;
            n_carry  = 1'b0;
        end else if (i_ctrl.div_step) begin
            // MSB nibble out, quotient nibble in at the bottom
            n_mant = {r_mant[MANT_W-NIB_W-1:0], qr[7:4]};
            n_rem  = qr[3:0];
            if (i_ctrl.first) begin
                n_sticky = r_sticky | (r_last != 4'd0);
            end
            if (i_ctrl.last) begin
                n_last = qr[3:0];
            end
        end else if (i_ctrl.inc_step) begin
            // LSB nibble first, rotate right with ripple carry
            n_mant  = {sum[3:0], r_mant[MANT_W-1:NIB_W]};
            n_carry = sum[4];
        end
    end

    always_ff @(posedge i_clk) begin
        r_mant   <= n_mant;
        r_rem    <= n_rem;
        r_last   <= n_last;
        r_sticky <= n_sticky;
        r_carry  <= n_carry;
    end

    assign o_mant            = r_mant;
    assign o_stat.last_digit = r_last;
    assign o_stat.sticky     = r_sticky;
    assign o_stat.lsb        = r_mant[0];

endmodule

@@ hdl/decimal96_rounding_unit_top.sv @@
// Top level of the 96-bit decimal truncate, floor, round and negate unit.
//
// One item is worked on at a time. Negate goes from acceptance straight to the
// done state. Truncate, floor and round divide by ten once per digit removed
// (scale clamped to MAX_SCALE): the mantissa sits in a 96-bit shift register and
// each division by ten walks it one 4-bit nibble per cycle, most significant
// first; a final pass, least significant nibble first, adds the rounding
// increment. The result goes into an output register, so a new item is taken
// while the last result still waits for its consumer. Negative zero is kept as
// given.
module decimal96_rounding_unit_top #(
    parameter int MAX_SCALE = 28
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dec96_in_if.sink    i_in,
    dec96_out_if.source o_out
);
    import dec96_pkg::*;

    t_state             r_state, n_state;
    logic [NIB_CW-1:0]  r_nib, n_nib;
    logic [4:0]         r_todo, n_todo;
    t_op                r_op, n_op;
    logic               r_sign, n_sign;
    logic [4:0]         r_scale, n_scale;
    logic               r_ovalid, n_ovalid;
    logic [MANT_W-1:0]  r_res;
    logic               r_res_sign;
    logic [4:0]         r_res_scale;

    t_dp_ctrl           ctrl;
    t_dp_stat           stat;
    logic [MANT_W-1:0]  mant;
    logic [4:0]         sc_clamp;
    logic               accept;
    logic               nib_last;
    logic               bump;
    logic               out_load;

    dec96_datapath u_dp (
        .i_clk       (i_clk),
        .i_ctrl      (ctrl),
        .i_load_mant ({i_in.mant_hi, i_in.mant_lo}),
        .o_mant      (mant),
        .o_stat      (stat)
    );

    // Clamp out-of-range scales for every operation
    assign sc_clamp = (i_in.scale > 5'(MAX_SCALE)) ? 5'(MAX_SCALE) : i_in.scale;
    assign i_in.ready = (r_state == ST_IDLE);
    assign accept   = i_in.valid & i_in.ready;
    assign nib_last = (r_nib == NIB_CW'(NIBBLES - 1));
    assign out_load = (r_state == ST_DONE) && (!r_ovalid || o_out.ready);

    // Rounding decision from the last discarded digit, the sticky flag, the sign and the LSB
    always_comb begin
        case (r_op)
            OP_FLOOR: bump = r_sign && ((stat.last_digit != 4'd0) || stat.sticky);
            OP_ROUND: bump = (stat.last_digit > 4'd5) ||
                             ((stat.last_digit == 4'd5) && (stat.sticky || stat.lsb));
            default:  bump = 1'b0;
        endcase
    end

    always_comb begin
        ctrl.load     = accept;
        ctrl.div_step = (r_state == ST_DIV);
        ctrl.inc_step = (r_state == ST_INC);
        ctrl.first    = (r_nib == '0);
        ctrl.last     = nib_last;
        ctrl.bump     = bump;
    end

    always_comb begin
        n_state  = r_state;
        n_nib    = r_nib;
        n_todo   = r_todo;
        n_op     = r_op;
        n_sign   = r_sign;
        n_scale  = r_scale;
        n_ovalid = r_ovalid;
        if (o_out.valid && o_out.ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_op   = t_op'(i_in.op);
                    n_nib  = '0;
                    n_todo = sc_clamp;
                    if (t_op'(i_in.op) == OP_NEGATE) begin
                        n_sign  = ~i_in.sign;
                        n_scale = sc_clamp;
                        n_state = ST_DONE;
                    end else begin
                        n_sign  = i_in.sign;
                        n_scale = '0;
                        n_state = (sc_clamp == 5'd0) ? ST_INC : ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                n_nib = r_nib + 1'b1;
                if (nib_last) begin
                    n_nib  = '0;
                    n_todo = r_todo - 5'd1;
                    if (r_todo == 5'd1) begin
                        n_state = ST_INC;
                    end
                end
            end
            ST_INC: begin
                n_nib = r_nib + 1'b1;
                if (nib_last) begin
                    n_nib   = '0;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_nib    <= '0;
            r_todo   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_nib    <= n_nib;
            r_todo   <= n_todo;
            r_ovalid <= n_ovalid;
        end
    end

    // Hold the working item's attributes and the result payload
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_sign  <= n_sign;
        r_scale <= n_scale;
        if (out_load) begin
            r_res       <= mant;
            r_res_sign  <= r_sign;
            r_res_scale <= r_scale;
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.res_lo    = r_res[63:0];
    assign o_out.res_hi    = r_res[MANT_W-1:64];
    assign o_out.res_scale = r_res_scale;
    assign o_out.res_sign  = r_res_sign;

    a_nib_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nib <= NIB_CW'(NIBBLES - 1))
        else $error("nibble counter out of range");

    a_div_todo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_todo != 5'd0))
        else $error("division pass with no digits left");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == ST_DONE))
        else $error("result raised outside completion");

    a_idle_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_state == ST_IDLE) && r_ovalid)
        else $error("result load did not return to idle");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the 96-bit decimal truncate, floor, round and negate unit.
module tb;
    import dec96_pkg::*;

    // The block clamps any scale above this to it; match the default of the top level.
    localparam int MAX_SCALE = 28;
    // Bound on the slowest item, with the scale clamped to MAX_SCALE.
    localparam int ITEM_CYCLES = 24 * MAX_SCALE + 26;
    // Cycles to let pass after the last result, so a stray extra result would show.
    localparam int TAIL_CYCLES = ITEM_CYCLES + 50;
    // Cycles without any handshake before the run is declared hung: the slowest item
    // plus long stalls on both sides, several times over.
    localparam int STALL_LIMIT = 10 * ITEM_CYCLES;
    localparam int PRINT_CAP = 40;
    localparam logic [95:0] MANT_MAX = {96{1'b1}};

    typedef struct packed {
        t_op         op;
        logic [95:0] mant;
        logic [4:0]  scale;
        logic        sign;
    } t_operand;

    typedef struct packed {
        logic [95:0] mant;
        logic [4:0]  scale;
        logic        sign;
    } t_dec_result;

    typedef struct packed {
        t_operand    opd;
        t_dec_result res;
    } t_pending;

    logic clk;
    logic rst_n;
    bit   idle_on = 1'b1;

    t_pending due_results[$];
    int       mismatch_count = 0;
    int       results_checked = 0;
    int       op_count[4] = '{default: 0};
    int       clamped_count = 0;
    int       stall_cycles = 0;

    dec96_in_if  opd_ch ();
    dec96_out_if res_ch ();

    decimal96_rounding_unit_top #(
        .MAX_SCALE(MAX_SCALE)
    ) i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (opd_ch),
        .o_out  (res_ch)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Ten to the power n, at mantissa width; n never exceeds the clamped scale.
    function automatic logic [95:0] pow10(int unsigned n);
        logic [95:0] p;
        p = 96'd1;
        for (int k = 0; k < n; k++) p = p * 96'd10;
        return p;
    endfunction

    // Predict the result of one operand item. Divide digit by digit so that the last
    // digit dropped and whether any earlier dropped digit was nonzero are both known;
    // those two, with the sign for floor and the kept LSB for round, decide the increments.
    function automatic t_dec_result rounded_value(t_operand opd);
        t_dec_result r;
        logic [95:0] mag;
        logic [3:0]  digit;
        logic        dropped_nz;
        logic        carry;
        int unsigned eff_scale;
        mag        = opd.mant;
        digit      = 4'd0;
        dropped_nz = 1'b0;
        carry      = 1'b0;
        eff_scale  = (opd.scale > MAX_SCALE) ? MAX_SCALE : opd.scale;
        r.scale    = 5'd0;
        r.sign     = opd.sign;
        if (opd.op == OP_NEGATE) begin
            // Flip the sign only; the clamped scale is reported back.
            r.sign  = ~opd.sign;
            r.scale = 5'(eff_scale);
        end else begin
            for (int k = 0; k < eff_scale; k++) begin
                dropped_nz = dropped_nz | (digit != 4'd0);
                digit      = 4'(mag % 96'd10);
                mag        = mag / 96'd10;
            end
            case (opd.op)
                // Toward minus infinity: grow the magnitude of a negative value only
                // when something nonzero was thrown away.
                OP_FLOOR: carry = opd.sign && (digit != 4'd0 || dropped_nz);
                // Half to even: above half goes up, exact half goes to the even side.
                OP_ROUND: carry = (digit > 4'd5) ||
                                  (digit == 4'd5 && (dropped_nz || mag[0]));
                default:  carry = 1'b0;
            endcase
            mag = mag + 96'(carry);
        end
        r.mant = mag;
        return r;
    endfunction

    // Print one line per mismatch (up to a cap) and count every one.
    task automatic report_mismatch(string msg);
        if (mismatch_count < PRINT_CAP) $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Offer one operand item and hold it until the block takes it. Entered and left
    // just after a falling edge, with valid low.
    task automatic send_operand(t_op op, logic [95:0] mant, logic [4:0] scale, logic sign);
        t_operand opd;
        opd = '{op: op, mant: mant, scale: scale, sign: sign};
        // Idle the sender for a random number of cycles.
        while (idle_on && $urandom_range(99) < 30) @(negedge clk);
        opd_ch.valid   = 1'b1;
        opd_ch.op      = op;
        opd_ch.mant_lo = mant[63:0];
        opd_ch.mant_hi = mant[95:64];
        opd_ch.scale   = scale;
        opd_ch.sign    = sign;
        do @(posedge clk); while (!opd_ch.ready);
        due_results.push_back('{opd: opd, res: rounded_value(opd)});
        op_count[op]++;
        if (scale > MAX_SCALE) clamped_count++;
        @(negedge clk);
        opd_ch.valid = 1'b0;
    endtask

    // Hold the sender until every outstanding result has come back.
    task automatic wait_drain();
        while (due_results.size() != 0) @(negedge clk);
    endtask

    // Negate: sign flips, mantissa kept, scale kept but clamped; negative zero too.
    task automatic test_negate();
        send_operand(OP_NEGATE, 96'd0, 5'd0, 1'b0);
        send_operand(OP_NEGATE, MANT_MAX, 5'd28, 1'b1);
        send_operand(OP_NEGATE, 96'd12345, 5'd31, 1'b0);
        send_operand(OP_NEGATE, MANT_MAX, 5'd29, 1'b1);
    endtask

    // Scale zero: the rounding operations pass mantissa and sign straight through.
    task automatic test_scale_zero();
        send_operand(OP_TRUNC, MANT_MAX, 5'd0, 1'b1);
        send_operand(OP_FLOOR, MANT_MAX, 5'd0, 1'b1);
        send_operand(OP_ROUND, MANT_MAX, 5'd0, 1'b0);
        send_operand(OP_ROUND, 96'd7, 5'd0, 1'b1);
    endtask

    // Floor and truncate: zero and nonzero fractions on negative values, magnitude below one,
    // a positive value, zero and the full mantissa at the top scale, and beyond it.
    task automatic test_floor_negative();
        send_operand(OP_FLOOR, 96'd1200, 5'd2, 1'b1);
        send_operand(OP_FLOOR, 96'd5, 5'd1, 1'b1);
        send_operand(OP_FLOOR, 96'd1201, 5'd2, 1'b1);
        send_operand(OP_FLOOR, 96'd1299, 5'd2, 1'b0);
        send_operand(OP_FLOOR, MANT_MAX, 5'd28, 1'b1);
        send_operand(OP_FLOOR, 96'd0, 5'd28, 1'b1);
        send_operand(OP_TRUNC, MANT_MAX, 5'd30, 1'b1);
        send_operand(OP_TRUNC, 96'd1299, 5'd2, 1'b1);
    endtask

    // Round: exact halves to both even neighbours, half of zero, a half with a
    // nonzero tail further down, just under half, and the largest mantissa.
    task automatic test_round_ties();
        send_operand(OP_ROUND, 96'd25, 5'd1, 1'b0);
        send_operand(OP_ROUND, 96'd35, 5'd1, 1'b0);
        send_operand(OP_ROUND, 96'd5, 5'd1, 1'b1);
        send_operand(OP_ROUND, 96'd2500001, 5'd6, 1'b0);
        send_operand(OP_ROUND, 96'd249999, 5'd5, 1'b0);
        send_operand(OP_ROUND, 96'd15, 5'd1, 1'b1);
        send_operand(OP_ROUND, MANT_MAX, 5'd28, 1'b0);
        send_operand(OP_ROUND, pow10(27) * 96'd5, 5'd28, 1'b1);
    endtask

    // Random items. Half the mantissas sit on or near a multiple of ten to the scale, so
    // that exact fractions, halves and near-halves come up often; the rest are full
    // width or small values. Scales cover the whole field, clamped values included.
    task automatic test_random_mix(int n_items);
        t_op         op;
        logic [95:0] raw;
        logic [95:0] p;
        logic [95:0] base;
        logic [95:0] offset;
        logic [95:0] mant;
        logic [4:0]  scale;
        int unsigned eff;
        int unsigned kind;
        for (int n = 0; n < n_items; n++) begin
            op    = t_op'($urandom_range(3));
            scale = 5'($urandom_range(31));
            kind  = $urandom_range(9);
            raw   = {$urandom, $urandom, $urandom};
            eff   = (scale > MAX_SCALE) ? MAX_SCALE : scale;
            p     = pow10(eff);
            if (kind < 3) begin
                mant = raw;
            end else if (kind < 5) begin
                mant = 96'($urandom_range(999));
            end else begin
                // Pick a quotient that leaves room for the offset below.
                if (eff <= 26 && $urandom_range(1)) begin
                    base = 96'($urandom_range(20));
                end else begin
                    base = raw / p;
                    if (base != 96'd0) base = base - 96'd1;
                end
                case ($urandom_range(5))
                    0:       offset = 96'd0;
                    1:       offset = p / 96'd2;
                    2:       offset = (p > 96'd1) ? p / 96'd2 + 96'd1 : 96'd0;
                    3:       offset = (p > 96'd1) ? p / 96'd2 - 96'd1 : 96'd0;
                    4:       offset = p - 96'd1;
                    default: offset = raw % p;
                endcase
                mant = base * p + offset;
            end
            send_operand(op, mant, scale, 1'($urandom_range(1)));
        end
    endtask

    // Steady flow: drop idling on both sides so items go back to back.
    task automatic test_steady_flow(int n_items);
        idle_on = 1'b0;
        test_random_mix(n_items);
        idle_on = 1'b1;
    endtask

    // Let the block run dry, then restart from empty with a fresh burst.
    task automatic test_drained_restart(int n_items);
        wait_drain();
        test_random_mix(n_items);
    endtask

    // Result side: stall at random at the falling edge, take items at the rising one.
    always @(negedge clk) begin
        res_ch.ready = idle_on ? ($urandom_range(99) >= 30) : 1'b1;
    end

    // Compare each accepted result, field by field, with the oldest prediction.
    always @(posedge clk) begin : result_check
        t_pending due;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("result %h_%h with nothing outstanding",
                                          res_ch.res_hi, res_ch.res_lo));
            end else begin
                due = due_results.pop_front();
                if (res_ch.res_lo !== due.res.mant[63:0])
                    report_mismatch($sformatf("%s m=%h s=%0d: res_lo %h, want %h",
                                              due.opd.op.name(), due.opd.mant,
                                              due.opd.scale, res_ch.res_lo,
                                              due.res.mant[63:0]));
                if (res_ch.res_hi !== due.res.mant[95:64])
                    report_mismatch($sformatf("%s m=%h s=%0d: res_hi %h, want %h",
                                              due.opd.op.name(), due.opd.mant,
                                              due.opd.scale, res_ch.res_hi,
                                              due.res.mant[95:64]));
                if (res_ch.res_scale !== due.res.scale)
                    report_mismatch($sformatf("%s m=%h s=%0d: res_scale %0d, want %0d",
                                              due.opd.op.name(), due.opd.mant,
                                              due.opd.scale, res_ch.res_scale,
                                              due.res.scale));
                if (res_ch.res_sign !== due.res.sign)
                    report_mismatch($sformatf("%s m=%h s=%0d: res_sign %b, want %b",
                                              due.opd.op.name(), due.opd.mant,
                                              due.opd.scale, res_ch.res_sign,
                                              due.res.sign));
                results_checked++;
            end
        end
    end

    // Watchdog: end the run if no item moves on either side for too long.
    always @(posedge clk) begin
        if (!rst_n || (opd_ch.valid && opd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, due_results.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        // Drive every input to a known value before reset.
        rst_n          = 1'b0;
        opd_ch.valid   = 1'b0;
        opd_ch.op      = OP_TRUNC;
        opd_ch.mant_lo = 64'd0;
        opd_ch.mant_hi = 32'd0;
        opd_ch.scale   = 5'd0;
        opd_ch.sign    = 1'b0;
        res_ch.ready   = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_negate();
        test_scale_zero();
        test_floor_negative();
        test_round_ties();
        test_random_mix(500);
        test_steady_flow(200);
        test_drained_restart(330);

        // Wait for the last results, then give any stray extra result time to show.
        wait_drain();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Sent %0d truncate, %0d floor, %0d round, %0d negate items (%0d clamped scale)",
                 op_count[OP_TRUNC], op_count[OP_FLOOR], op_count[OP_ROUND],
                 op_count[OP_NEGATE], clamped_count);
        $display("Checked %0d results, %0d mismatching fields", results_checked,
                 mismatch_count);
        if (mismatch_count == 0 && due_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
